FILE: design/cpt_pkg.sv
// Shared types and codes for the cluster partition table.
// No dependencies; imported by cluster_partition_table_top and cpt_ctrl.
`default_nettype none
package cpt_pkg;

   typedef enum logic [2:0] {
      OP_LOAD     = 3'd0,
      OP_MOVE     = 3'd1,
      OP_SWAP     = 3'd2,
      OP_CYCLE    = 3'd3,
      OP_QPOINT   = 3'd4,
      OP_QCLUSTER = 3'd5
   } cpt_op_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_BAD_POINT   = 2'd1,
      ST_BAD_CLUSTER = 2'd2,
      ST_NOT_DISTINCT = 2'd3
   } cpt_status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_RD_A,
      S_RD_B,
      S_RD_C,
      S_DECIDE,
      S_FILL_SRC,
      S_MV_LAST,
      S_MV_FIX,
      S_WR_1,
      S_WR_2,
      S_WR_3,
      S_QC_MEM,
      S_DONE
   } cpt_state_type;

   // register indexes of the CSR port
   localparam logic REG_POINT_TOTAL   = 1'b0;
   localparam logic REG_CLUSTER_TOTAL = 1'b1;

   typedef struct packed {
      logic [8:0] point_total;
      logic [4:0] cluster_total;
   } cpt_cfg_type;

endpackage
`default_nettype wire

FILE: design/cluster_partition_table_top.sv
// Cluster partition table: CSR block and transaction sequencer.
// Uses cpt_pkg and cpt_ctrl (which holds the cpt_ram instances).
// Usage:
//   req_* is a valid/ready channel carrying one command per transaction:
//   load, move, swap, three-way cycle, point query or cluster query.
//   rsp_* returns exactly one result per command, in order.
//   csr_* is an APB-style port: point_total at 0x0, cluster_total at 0x4.
//   Write these only while no transaction is in flight.
// Timing:
//   One transaction in flight; req_ready is high only while the sequencer is
//   idle. Single-ported memories set the steps: reads, a decide step, then
//   any write steps. Range errors and unknown commands skip to the result;
//   swap within one cluster and cycle with repeated clusters skip the writes;
//   cluster query adds a member read for a valid index. The result is registered
//   as the sequencer returns to idle, so the next command can be taken at once.
// Reset:
//   Synchronous reset loads the CSR defaults, then the fill counts are cleared
//   one cluster per cycle with req_ready low.
// Stalls:
//   The result waits in an output register; a new command is taken meanwhile
//   and its result is held by the sequencer until the register frees.
`default_nettype none
module cluster_partition_table_top #(
   parameter int MAX_POINTS   = 256,
   parameter int MAX_CLUSTERS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_type,
   input  wire logic [7:0]  req_point_a,
   input  wire logic [7:0]  req_point_b,
   input  wire logic [7:0]  req_point_c,
   input  wire logic [3:0]  req_cluster_sel,
   input  wire logic [7:0]  req_member_index,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [3:0]       rsp_out_label,
   output logic [7:0]       rsp_out_position,
   output logic [8:0]       rsp_out_size,
   output logic [7:0]       rsp_out_member,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import cpt_pkg::*;

   cpt_cfg_type cfg_ff, cfg_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            REG_POINT_TOTAL:   cfg_in.point_total   = csr_pwdata[8:0];
            REG_CLUSTER_TOTAL: cfg_in.cluster_total = csr_pwdata[4:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_POINT_TOTAL:   csr_prdata = {23'd0, cfg_ff.point_total};
         REG_CLUSTER_TOTAL: csr_prdata = {27'd0, cfg_ff.cluster_total};
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.point_total   <= 9'd256;
         cfg_ff.cluster_total <= 5'd16;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cpt_ctrl #(
      .MAX_POINTS  (MAX_POINTS),
      .MAX_CLUSTERS(MAX_CLUSTERS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_point_a     (req_point_a),
      .req_point_b     (req_point_b),
      .req_point_c     (req_point_c),
      .req_cluster_sel (req_cluster_sel),
      .req_member_index(req_member_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_out_label   (rsp_out_label),
      .rsp_out_position(rsp_out_position),
      .rsp_out_size    (rsp_out_size),
      .rsp_out_member  (rsp_out_member)
   );

endmodule
`default_nettype wire

FILE: design/cpt_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module cpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end else begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

FILE: design/cpt_ctrl.sv
// Sequencer for the partition table: owns the label, position, member and
// fill memories and runs read-modify-write steps per transaction. Uses cpt_pkg, cpt_ram.
`default_nettype none
module cpt_ctrl #(
   parameter int MAX_POINTS   = 256,
   parameter int MAX_CLUSTERS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cpt_pkg::cpt_cfg_type cfg,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [2:0]          req_type,
   input  wire logic [7:0]          req_point_a,
   input  wire logic [7:0]          req_point_b,
   input  wire logic [7:0]          req_point_c,
   input  wire logic [3:0]          req_cluster_sel,
   input  wire logic [7:0]          req_member_index,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [1:0]               rsp_status,
   output logic [3:0]               rsp_out_label,
   output logic [7:0]               rsp_out_position,
   output logic [8:0]               rsp_out_size,
   output logic [7:0]               rsp_out_member
);
   import cpt_pkg::*;

   localparam int PW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_CLUSTERS);
   localparam int FW = $clog2(MAX_POINTS + 1);
   localparam int AW = $clog2(MAX_CLUSTERS * MAX_POINTS);

   function automatic logic [AW-1:0] slot(input logic [CW-1:0] c, input logic [PW-1:0] p);
      return AW'(c) * AW'(MAX_POINTS) + AW'(p);
   endfunction

   function automatic logic pt_ok(input logic [7:0] p, input logic [8:0] tot);
      return ({1'b0, p} < tot) && (32'(p) < 32'(MAX_POINTS));
   endfunction

   function automatic logic cl_ok(input logic [3:0] c, input logic [4:0] tot);
      return ({1'b0, c} < tot) && (32'(c) < 32'(MAX_CLUSTERS));
   endfunction

   cpt_state_type state_ff, state_in;
   logic [CW-1:0] clr_ff, clr_in;

   logic [2:0] op_ff, op_in;
   logic [7:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, mi_ff, mi_in;
   logic [3:0] cs_ff, cs_in;
   logic [CW-1:0] la_ff, la_in, lb_ff, lb_in, lc_ff, lc_in;
   logic [PW-1:0] qa_ff, qa_in, qb_ff, qb_in, qc_ff, qc_in;
   logic [FW-1:0] ft_ff, ft_in, fs_ff, fs_in;

   logic [1:0] res_status_ff, res_status_in;
   logic [3:0] res_label_ff, res_label_in;
   logic [7:0] res_pos_ff, res_pos_in, res_mem_ff, res_mem_in;
   logic [8:0] res_size_ff, res_size_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [3:0] rsp_label_ff, rsp_label_in;
   logic [7:0] rsp_pos_ff, rsp_pos_in, rsp_mem_ff, rsp_mem_in;
   logic [8:0] rsp_size_ff, rsp_size_in;

   logic          l_we, p_we, m_we, f_we;
   logic [PW-1:0] l_addr, p_addr;
   logic [AW-1:0] m_addr;
   logic [CW-1:0] f_addr;
   logic [CW-1:0] l_wdata, rd_lab;
   logic [PW-1:0] p_wdata, rd_pos, m_wdata, rd_mem;
   logic [FW-1:0] f_wdata, rd_fill;

   logic [PW-1:0] pa, pb, pc;
   logic [CW-1:0] cs;

   assign pa = PW'(a_ff);
   assign pb = PW'(b_ff);
   assign pc = PW'(c_ff);
   assign cs = CW'(cs_ff);

   cpt_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_label (
      .clock(clock), .we(l_we), .addr(l_addr), .wdata(l_wdata), .rdata(rd_lab));
   cpt_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_position (
      .clock(clock), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(rd_pos));
   cpt_ram #(.WIDTH(PW), .DEPTH(MAX_CLUSTERS * MAX_POINTS)) u_member (
      .clock(clock), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(rd_mem));
   cpt_ram #(.WIDTH(FW), .DEPTH(MAX_CLUSTERS)) u_fill (
      .clock(clock), .we(f_we), .addr(f_addr), .wdata(f_wdata), .rdata(rd_fill));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;  a_ff <= a_in;  b_ff <= b_in;  c_ff <= c_in;
      cs_ff <= cs_in;  mi_ff <= mi_in;
      la_ff <= la_in;  lb_ff <= lb_in;  lc_ff <= lc_in;
      qa_ff <= qa_in;  qb_ff <= qb_in;  qc_ff <= qc_in;
      ft_ff <= ft_in;  fs_ff <= fs_in;
      res_status_ff <= res_status_in;  res_label_ff <= res_label_in;
      res_pos_ff    <= res_pos_in;     res_size_ff  <= res_size_in;
      res_mem_ff    <= res_mem_in;
      rsp_status_ff <= rsp_status_in;  rsp_label_ff <= rsp_label_in;
      rsp_pos_ff    <= rsp_pos_in;     rsp_size_ff  <= rsp_size_in;
      rsp_mem_ff    <= rsp_mem_in;
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      op_in = op_ff;  a_in = a_ff;  b_in = b_ff;  c_in = c_ff;
      cs_in = cs_ff;  mi_in = mi_ff;
      la_in = la_ff;  lb_in = lb_ff;  lc_in = lc_ff;
      qa_in = qa_ff;  qb_in = qb_ff;  qc_in = qc_ff;
      ft_in = ft_ff;  fs_in = fs_ff;
      res_status_in = res_status_ff;  res_label_in = res_label_ff;
      res_pos_in    = res_pos_ff;     res_size_in  = res_size_ff;
      res_mem_in    = res_mem_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_status_in = rsp_status_ff;  rsp_label_in = rsp_label_ff;
      rsp_pos_in    = rsp_pos_ff;     rsp_size_in  = rsp_size_ff;
      rsp_mem_in    = rsp_mem_ff;

      l_we = 1'b0;  l_addr = pa;  l_wdata = cs;
      p_we = 1'b0;  p_addr = pa;  p_wdata = '0;
      m_we = 1'b0;  m_addr = slot(cs, PW'(mi_ff));  m_wdata = pa;
      f_we = 1'b0;  f_addr = cs;  f_wdata = '0;

      req_ready = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            f_we    = 1'b1;
            f_addr  = clr_ff;
            f_wdata = '0;
            if (clr_ff == CW'(MAX_CLUSTERS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + CW'(1);
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in = req_type;  a_in = req_point_a;  b_in = req_point_b;
               c_in = req_point_c;  cs_in = req_cluster_sel;  mi_in = req_member_index;
               res_status_in = ST_OK;  res_label_in = '0;  res_pos_in = '0;
               res_size_in = '0;  res_mem_in = '0;
               state_in = S_RD_A;
            end
         end
         S_RD_A: begin
            // reads of L[a], P[a], F[cluster_sel] issued by default addresses
            state_in = S_DECIDE;
            case (op_ff)
               OP_LOAD, OP_MOVE: begin
                  if (!pt_ok(a_ff, cfg.point_total)) begin
                     res_status_in = ST_BAD_POINT;  state_in = S_DONE;
                  end else if (!cl_ok(cs_ff, cfg.cluster_total)) begin
                     res_status_in = ST_BAD_CLUSTER;  state_in = S_DONE;
                  end
               end
               OP_SWAP: begin
                  if (!pt_ok(a_ff, cfg.point_total) || !pt_ok(b_ff, cfg.point_total)) begin
                     res_status_in = ST_BAD_POINT;  state_in = S_DONE;
                  end else begin
                     state_in = S_RD_B;
                  end
               end
               OP_CYCLE: begin
                  if (!pt_ok(a_ff, cfg.point_total) || !pt_ok(b_ff, cfg.point_total) ||
                      !pt_ok(c_ff, cfg.point_total)) begin
                     res_status_in = ST_BAD_POINT;  state_in = S_DONE;
                  end else begin
                     state_in = S_RD_B;
                  end
               end
               OP_QPOINT: begin
                  if (!pt_ok(a_ff, cfg.point_total)) begin
                     res_status_in = ST_BAD_POINT;  state_in = S_DONE;
                  end
               end
               OP_QCLUSTER: begin
                  if (!cl_ok(cs_ff, cfg.cluster_total)) begin
                     res_status_in = ST_BAD_CLUSTER;  state_in = S_DONE;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_RD_B: begin
            la_in  = rd_lab;
            qa_in  = rd_pos;
            l_addr = pb;
            p_addr = pb;
            state_in = (op_ff == OP_CYCLE) ? S_RD_C : S_DECIDE;
         end
         S_RD_C: begin
            lb_in  = rd_lab;
            qb_in  = rd_pos;
            l_addr = pc;
            p_addr = pc;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_DONE;
            case (op_ff)
               OP_LOAD: begin
                  if (32'(rd_fill) >= 32'(MAX_POINTS)) begin
                     res_status_in = ST_BAD_CLUSTER;
                  end else begin
                     m_we = 1'b1;  m_addr = slot(cs, PW'(rd_fill));  m_wdata = pa;
                     f_we = 1'b1;  f_wdata = rd_fill + FW'(1);
                     l_we = 1'b1;  l_wdata = cs;
                     p_we = 1'b1;  p_wdata = PW'(rd_fill);
                  end
               end
               OP_MOVE: begin
                  la_in = rd_lab;
                  qa_in = rd_pos;
                  ft_in = rd_fill;
                  if (rd_lab == cs) begin
                     state_in = S_DONE;
                  end else if (32'(rd_fill) >= 32'(MAX_POINTS)) begin
                     res_status_in = ST_BAD_CLUSTER;
                  end else begin
                     f_addr   = rd_lab;
                     state_in = S_FILL_SRC;
                  end
               end
               OP_SWAP: begin
                  lb_in = rd_lab;
                  qb_in = rd_pos;
                  if (rd_lab != la_ff) begin
                     state_in = S_WR_1;
                  end
               end
               OP_CYCLE: begin
                  lc_in = rd_lab;
                  qc_in = rd_pos;
                  if (la_ff == lb_ff || lb_ff == rd_lab || rd_lab == la_ff) begin
                     res_status_in = ST_NOT_DISTINCT;
                  end else begin
                     state_in = S_WR_1;
                  end
               end
               OP_QPOINT: begin
                  res_label_in = 4'(rd_lab);
                  res_pos_in   = 8'(rd_pos);
               end
               OP_QCLUSTER: begin
                  res_size_in = 9'(rd_fill);
                  if (32'(mi_ff) < 32'(rd_fill)) begin
                     state_in = S_QC_MEM;
                  end else begin
                     res_status_in = ST_BAD_CLUSTER;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_FILL_SRC: begin
            // append bookkeeping on target, fetch last member of source
            fs_in   = rd_fill;
            l_we    = 1'b1;  l_wdata = cs;
            f_we    = 1'b1;  f_addr = cs;  f_wdata = ft_ff + FW'(1);
            m_addr  = slot(la_ff, PW'(rd_fill - FW'(1)));
            state_in = (rd_fill == '0) ? S_MV_FIX : S_MV_LAST;
         end
         S_MV_LAST: begin
            m_we = 1'b1;  m_addr = slot(la_ff, qa_ff);  m_wdata = rd_mem;
            p_we = 1'b1;  p_addr = rd_mem;  p_wdata = qa_ff;
            f_we = 1'b1;  f_addr = la_ff;  f_wdata = fs_ff - FW'(1);
            state_in = S_MV_FIX;
         end
         S_MV_FIX: begin
            // after the source fix-up so a moved last entry cannot clobber it
            m_we = 1'b1;  m_addr = slot(cs, PW'(ft_ff));  m_wdata = pa;
            p_we = 1'b1;  p_wdata = PW'(ft_ff);
            state_in = S_DONE;
         end
         S_WR_1: begin
            m_we = 1'b1;  m_addr = slot(la_ff, qa_ff);
            m_wdata = (op_ff == OP_SWAP) ? pb : pc;
            l_we = 1'b1;  l_wdata = lb_ff;
            p_we = 1'b1;  p_wdata = qb_ff;
            state_in = S_WR_2;
         end
         S_WR_2: begin
            m_we = 1'b1;  m_addr = slot(lb_ff, qb_ff);  m_wdata = pa;
            l_we = 1'b1;  l_addr = pb;
            p_we = 1'b1;  p_addr = pb;
            if (op_ff == OP_SWAP) begin
               l_wdata  = la_ff;
               p_wdata  = qa_ff;
               state_in = S_DONE;
            end else begin
               l_wdata  = lc_ff;
               p_wdata  = qc_ff;
               state_in = S_WR_3;
            end
         end
         S_WR_3: begin
            m_we = 1'b1;  m_addr = slot(lc_ff, qc_ff);  m_wdata = pb;
            l_we = 1'b1;  l_addr = pc;  l_wdata = la_ff;
            p_we = 1'b1;  p_addr = pc;  p_wdata = qa_ff;
            state_in = S_DONE;
         end
         S_QC_MEM: begin
            res_mem_in = 8'(rd_mem);
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_label_in  = res_label_ff;
               rsp_pos_in    = res_pos_ff;
               rsp_size_in   = res_size_ff;
               rsp_mem_in    = res_mem_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_label    = rsp_label_ff;
   assign rsp_out_position = rsp_pos_ff;
   assign rsp_out_size     = rsp_size_ff;
   assign rsp_out_member   = rsp_mem_ff;

endmodule
`default_nettype wire
